>>> design/tti_pkg.sv
package tti_pkg;

    // field and register widths
    localparam int FULL_W     = 21;
    localparam int TICKS_W    = 7;
    localparam int KIND_W     = 3;
    localparam int VAL_W      = 21;
    localparam int EV_W       = 2;
    localparam int TS_W       = 32;
    localparam int OFS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // internal widths
    localparam int HALF_W     = 20;               // clamped half interval in us
    localparam int MATCH_W    = 27;               // 1000000 * 127 fits
    localparam int SUM_W      = 22;               // signed sums of us values
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 20;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIVD_W     = MATCH_W + HALF_W; // count times half
    localparam int DIV_STEPS  = DIVD_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    // limits
    localparam int HALF_MIN     = 100;
    localparam int HALF_MAX     = 1000000;
    localparam int OFFSET_LIMIT = 500;

    // reset values
    localparam int FULL_RESET  = 5000;
    localparam int TICKS_RESET = 2;
    localparam int BASE_RESET  = 2500 * 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FULL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS = CFG_IDX_W'(1);

    // event codes
    localparam logic [EV_W-1:0] EV_NONE = 2'd0;
    localparam logic [EV_W-1:0] EV_TICK = 2'd1;
    localparam logic [EV_W-1:0] EV_TOCK = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        K_CLOCK   = 3'd0,
        K_PHASE   = 3'd1,
        K_OFS_ADD = 3'd2,
        K_OFS_CLR = 3'd3,
        K_START   = 3'd4,
        K_STOP    = 3'd5,
        K_PAUSE   = 3'd6,
        K_RESUME  = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FIRE,
        S_MULTS,
        S_MULFR,
        S_DIV,
        S_DONE
    } t_state;

endpackage

>>> design/tti_in_if.sv
interface tti_in_if import tti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

>>> design/tti_out_if.sv
interface tti_out_if import tti_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [EV_W-1:0]         event_res;
    logic [TS_W-1:0]         timestamp_us;
    logic signed [OFS_W-1:0] frequency_offset;
    logic                    active;

    modport source (output valid, output event_res, output timestamp_us,
                    output frequency_offset, output active, input ready);
    modport sink   (input valid, input event_res, input timestamp_us,
                    input frequency_offset, input active, output ready);
endinterface

>>> design/tick_tock_interval_timer_top.sv
// channel    | dir | handshake      | payload
// -----------+-----+----------------+------------------------------------------------
// i_item     | in  | valid / ready  | kind[2:0], value[20:0] signed
// o_result   | out | valid / ready  | event_res[1:0], timestamp_us[31:0],
//            |     |                | frequency_offset[9:0] signed, active
// i_cfg_*    | in  | write enable   | i_cfg_idx[1:0], i_cfg_data[20:0]
//
// an item runs exec, fire when it raises an event, the two timestamp products and the
// bit-serial restoring divider (47 steps), then waits in done for the output register
// one shared 32x20 multiplier serves base, match, and both timestamp products in turn
// reset is synchronous active low and loads the register and timer reset values
// a finished beat sits in the output register; the next item is taken while it waits
// config writes must come while idle, unenforced; base, and match if active, rebuild
module tick_tock_interval_timer_top import tti_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tti_in_if.sink                i_item,
    tti_out_if.source             o_result
);

    // state
    t_state                   r_state, n_state;
    logic [FULL_W-1:0]        r_full;
    logic [TICKS_W-1:0]       r_ticks;
    logic                     r_cfg_pend;
    logic [MATCH_W-1:0]       r_pc;
    logic [MATCH_W-1:0]       r_cur_match;
    logic [MATCH_W-1:0]       r_base_match;
    logic [TS_W-1:0]          r_half_events;
    logic                     r_tock;
    logic                     r_running;
    logic                     r_paused;
    logic signed [VAL_W-1:0]  r_pending;
    logic signed [OFS_W-1:0]  r_ofs;

    // per-item working registers
    t_kind                    r_kind;
    logic signed [VAL_W-1:0]  r_val;
    logic [EV_W-1:0]          r_ev;
    logic [HALF_W-1:0]        r_next_us;
    logic [TS_W-1:0]          r_ts_base;
    logic [DIVD_W-1:0]        r_quo;
    logic [MATCH_W-1:0]       r_rem;
    logic [CNT_W-1:0]         r_cnt;

    // output register
    logic                     r_out_valid;
    logic [EV_W-1:0]          r_out_ev;
    logic [TS_W-1:0]          r_out_ts;
    logic signed [OFS_W-1:0]  r_out_ofs;
    logic                     r_out_act;

    // combinational
    logic                     w_accept;
    logic                     w_in_ready;
    logic                     w_load;
    logic                     w_active;
    logic [HALF_W-1:0]        w_half;
    logic [TICKS_W-1:0]       w_ticks;
    logic [MATCH_W-1:0]       w_pc_inc;
    logic                     w_fire;
    logic signed [SUM_W-1:0]  w_next_sum;
    logic [HALF_W-1:0]        w_next_us;
    logic signed [SUM_W-1:0]  w_val_x;
    logic signed [SUM_W-1:0]  w_ph_hi;
    logic signed [SUM_W-1:0]  w_ph_lo;
    logic signed [VAL_W-1:0]  w_phase;
    logic signed [SUM_W-1:0]  w_ofs_sum;
    logic signed [OFS_W-1:0]  w_ofs_new;
    logic [MUL_A_W-1:0]       w_mul_a;
    logic [MUL_B_W-1:0]       w_mul_b;
    logic [PROD_W-1:0]        w_prod;
    logic [MATCH_W:0]         w_trial;
    logic                     w_ge;

    assign w_accept = i_item.valid && w_in_ready;
    assign w_active = r_running && !r_paused;

    // half interval and effective tick rate
    always_comb begin
        w_half = r_full[FULL_W-1:1];
        if (w_half < HALF_W'(HALF_MIN)) w_half = HALF_W'(HALF_MIN);
        if (w_half > HALF_W'(HALF_MAX)) w_half = HALF_W'(HALF_MAX);
        w_ticks = (r_ticks == '0) ? TICKS_W'(1) : r_ticks;
    end

    // clock count and match
    assign w_pc_inc = r_pc + MATCH_W'(1);
    assign w_fire   = (r_kind == K_CLOCK) && w_active && (w_pc_inc >= r_cur_match);

    // next half period in us, phase shift only on a tock
    always_comb begin
        w_next_sum = $signed({2'b00, w_half})
                   + $signed({{(SUM_W-OFS_W){r_ofs[OFS_W-1]}}, r_ofs});
        if (r_tock)
            w_next_sum = w_next_sum
                       + $signed({{(SUM_W-VAL_W){r_pending[VAL_W-1]}}, r_pending});
        if (w_next_sum < $signed(SUM_W'(HALF_MIN)))
            w_next_us = HALF_W'(HALF_MIN);
        else if (w_next_sum > $signed(SUM_W'(HALF_MAX)))
            w_next_us = HALF_W'(HALF_MAX);
        else
            w_next_us = w_next_sum[HALF_W-1:0];
    end

    // phase shift saturation
    always_comb begin
        w_val_x = $signed({{(SUM_W-VAL_W){r_val[VAL_W-1]}}, r_val});
        w_ph_hi = $signed(SUM_W'(HALF_MAX)) - $signed({2'b00, w_half});
        w_ph_lo = $signed(SUM_W'(HALF_MIN)) - $signed({2'b00, w_half});
        if (w_val_x > w_ph_hi)
            w_phase = w_ph_hi[VAL_W-1:0];
        else if (w_val_x < w_ph_lo)
            w_phase = w_ph_lo[VAL_W-1:0];
        else
            w_phase = r_val;
    end

    // offset accumulate with saturation
    always_comb begin
        w_ofs_sum = $signed({{(SUM_W-OFS_W){r_ofs[OFS_W-1]}}, r_ofs}) + w_val_x;
        if (w_ofs_sum > $signed(SUM_W'(OFFSET_LIMIT)))
            w_ofs_new = OFS_W'(OFFSET_LIMIT);
        else if (w_ofs_sum < -$signed(SUM_W'(OFFSET_LIMIT)))
            w_ofs_new = -$signed(OFS_W'(OFFSET_LIMIT));
        else
            w_ofs_new = w_ofs_sum[OFS_W-1:0];
    end

    // shared multiplier
    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // divider step
    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_base_match};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  n_state = w_fire ? S_FIRE : S_MULTS;
            S_FIRE:  n_state = S_MULTS;
            S_MULTS: n_state = S_MULFR;
            S_MULFR: n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_DONE;
            S_DONE:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: handshake and multiplier operands
    always_comb begin
        w_in_ready = 1'b0;
        w_load     = 1'b0;
        w_mul_a    = MUL_A_W'(w_half);
        w_mul_b    = MUL_B_W'(w_ticks);
        case (r_state)
            S_IDLE:  w_in_ready = 1'b1;
            S_FIRE:  begin
                w_mul_a = MUL_A_W'(r_next_us);
                w_mul_b = MUL_B_W'(w_ticks);
            end
            S_MULTS: begin
                w_mul_a = r_half_events;
                w_mul_b = MUL_B_W'(w_half);
            end
            S_MULFR: begin
                w_mul_a = MUL_A_W'(r_pc);
                w_mul_b = MUL_B_W'(w_half);
            end
            S_DONE:  w_load = !r_out_valid || o_result.ready;
            default: w_load = 1'b0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // timer state, config and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full        <= FULL_W'(FULL_RESET);
            r_ticks       <= TICKS_W'(TICKS_RESET);
            r_cfg_pend    <= 1'b0;
            r_pc          <= '0;
            r_cur_match   <= MATCH_W'(BASE_RESET);
            r_base_match  <= MATCH_W'(BASE_RESET);
            r_half_events <= '0;
            r_tock        <= 1'b1;
            r_running     <= 1'b0;
            r_paused      <= 1'b0;
            r_pending     <= '0;
            r_ofs         <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // rebuild base match after a register write
            if (r_state == S_IDLE && r_cfg_pend) begin
                r_base_match <= w_prod[MATCH_W-1:0];
                if (w_active) r_cur_match <= w_prod[MATCH_W-1:0];
            end

            // rebuild request, a fresh write outlasts a rebuild in the same cycle
            if (i_cfg_we && (i_cfg_idx == CFG_FULL || i_cfg_idx == CFG_TICKS))
                r_cfg_pend <= 1'b1;
            else if (r_state == S_IDLE)
                r_cfg_pend <= 1'b0;

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FULL:  r_full  <= i_cfg_data[FULL_W-1:0];
                    CFG_TICKS: r_ticks <= i_cfg_data[TICKS_W-1:0];
                    default: ;
                endcase
            end

            // item update
            if (r_state == S_EXEC) begin
                case (r_kind)
                    K_CLOCK: begin
                        if (w_active) begin
                            if (w_fire) begin
                                r_half_events <= r_half_events + TS_W'(1);
                                if (r_tock) r_pending <= '0;
                                r_pc   <= '0;
                                r_tock <= !r_tock;
                            end else begin
                                r_pc <= w_pc_inc;
                            end
                        end
                    end
                    K_PHASE:   r_pending <= w_phase;
                    K_OFS_ADD: r_ofs <= w_ofs_new;
                    K_OFS_CLR: r_ofs <= '0;
                    K_START: begin
                        if (!r_running) begin
                            r_running <= 1'b1;
                            r_paused  <= 1'b0;
                            r_tock    <= 1'b1;
                            r_pc      <= '0;
                        end
                    end
                    K_STOP:    r_running <= 1'b0;
                    K_PAUSE:   if (r_running && !r_paused) r_paused <= 1'b1;
                    K_RESUME: begin
                        if (r_running && r_paused) begin
                            r_tock   <= 1'b1;
                            r_paused <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            // new match after an event
            if (r_state == S_FIRE) r_cur_match <= w_prod[MATCH_W-1:0];

            // divider step count
            if (r_state == S_MULFR)
                r_cnt <= '0;
            else if (r_state == S_DIV)
                r_cnt <= r_cnt + CNT_W'(1);

            // output beat
            if (w_load)
                r_out_valid <= 1'b1;
            else if (o_result.ready)
                r_out_valid <= 1'b0;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_kind <= t_kind'(i_item.kind);
                    r_val  <= i_item.value;
                end
            end
            S_EXEC: begin
                r_next_us <= w_next_us;
                if (w_fire)
                    r_ev <= r_tock ? EV_TOCK : EV_TICK;
                else
                    r_ev <= EV_NONE;
            end
            S_MULTS: r_ts_base <= w_prod[TS_W-1:0];
            S_MULFR: begin
                r_quo <= w_prod[DIVD_W-1:0];
                r_rem <= '0;
            end
            S_DIV: begin
                r_rem <= w_ge ? (w_trial[MATCH_W-1:0] - r_base_match)
                              : w_trial[MATCH_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], w_ge};
            end
            S_DONE: begin
                if (w_load) begin
                    r_out_ev  <= r_ev;
                    r_out_ts  <= r_ts_base + r_quo[TS_W-1:0];
                    r_out_ofs <= r_ofs;
                    r_out_act <= w_active;
                end
            end
            default: ;
        endcase
    end

    assign i_item.ready              = w_in_ready;
    assign o_result.valid            = r_out_valid;
    assign o_result.event_res        = r_out_ev;
    assign o_result.timestamp_us     = r_out_ts;
    assign o_result.frequency_offset = r_out_ofs;
    assign o_result.active           = r_out_act;

    // checks
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted beat did not start execution");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_base_match)
        else $error("divider remainder out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside completion");

endmodule

>>> sim/tti_timer_checker.sv
`timescale 1ns / 1ps
module tti_timer_checker import tti_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tti_in_if                     i_item,
    tti_out_if                    i_result,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_items,
    output int                    o_events
);

    typedef struct packed {
        logic [EV_W-1:0]         ev;
        logic [TS_W-1:0]         ts;
        logic signed [OFS_W-1:0] ofs;
        logic                    act;
    } t_timer_beat;

    // register copies
    logic [FULL_W-1:0]  full_us;
    logic [TICKS_W-1:0] ticks;

    // timer state
    logic [31:0] count;
    logic [31:0] match;
    logic [31:0] base;
    logic [31:0] halves;
    logic        tock_next;
    logic        running;
    logic        paused;
    int          phase_pend;
    int          ofs_acc;

    // beats still owed by the block, oldest first
    t_timer_beat beats_due[$];

    function automatic int unsigned base_half_us();
        int unsigned h;
        h = full_us / 2;
        if (h < HALF_MIN) h = HALF_MIN;
        if (h > HALF_MAX) h = HALF_MAX;
        return h;
    endfunction

    // zero ticks per us counts as one
    function automatic int unsigned tick_scale();
        return (ticks == '0) ? 1 : ticks;
    endfunction

    function automatic int clamp(input int x, input int lo, input int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    task automatic timer_clear();
        full_us    = FULL_W'(FULL_RESET);
        ticks      = TICKS_W'(TICKS_RESET);
        count      = '0;
        base       = BASE_RESET;
        match      = BASE_RESET;
        halves     = '0;
        tock_next  = 1'b1;
        running    = 1'b0;
        paused     = 1'b0;
        phase_pend = 0;
        ofs_acc    = 0;
    endtask

    // register write: base rebuilt, live match follows when active
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FULL) begin
            full_us = data[FULL_W-1:0];
        end else if (idx == CFG_TICKS) begin
            ticks = data[TICKS_W-1:0];
        end else begin
            return;
        end
        base = base_half_us() * tick_scale();
        if (running && !paused) match = base;
    endtask

    task automatic timer_step(input t_kind k, input logic signed [VAL_W-1:0] v,
                              output t_timer_beat r);
        int unsigned     h;
        int              sv;
        int              nxt;
        logic [EV_W-1:0] ev;
        logic [63:0]     ts;
        h  = base_half_us();
        sv = v;
        ev = EV_NONE;
        case (k)
            K_CLOCK: begin
                if (running && !paused) begin
                    count = count + 1;
                    // fire: next half period, phase shift only on tock
                    if (count >= match) begin
                        nxt    = int'(h) + ofs_acc;
                        halves = halves + 1;
                        if (tock_next) begin
                            nxt        = nxt + phase_pend;
                            phase_pend = 0;
                            ev         = EV_TOCK;
                        end else begin
                            ev = EV_TICK;
                        end
                        nxt       = clamp(nxt, HALF_MIN, HALF_MAX);
                        match     = nxt * tick_scale();
                        count     = '0;
                        tock_next = !tock_next;
                    end
                end
            end
            K_PHASE: begin
                phase_pend = clamp(sv, HALF_MIN - int'(h), HALF_MAX - int'(h));
            end
            K_OFS_ADD: begin
                ofs_acc = clamp(ofs_acc + sv, -OFFSET_LIMIT, OFFSET_LIMIT);
            end
            K_OFS_CLR: begin
                ofs_acc = 0;
            end
            K_START: begin
                if (!running) begin
                    running   = 1'b1;
                    paused    = 1'b0;
                    tock_next = 1'b1;
                    count     = '0;
                end
            end
            K_STOP: begin
                running = 1'b0;
            end
            K_PAUSE: begin
                if (running && !paused) paused = 1'b1;
            end
            default: begin
                if (running && paused) begin
                    tock_next = 1'b1;
                    paused    = 1'b0;
                end
            end
        endcase
        ts = 64'(halves) * 64'(h) + (64'(count) * 64'(h)) / 64'(base);
        r.ev  = ev;
        r.ts  = ts[TS_W-1:0];
        r.ofs = ofs_acc[OFS_W-1:0];
        r.act = running && !paused;
    endtask

    task automatic field_mismatch(input string fname, input longint want,
                                  input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        o_fail_count++;
    endtask

    // model on accepted items, compare accepted beats
    always @(posedge i_clk) begin : watch
        t_timer_beat want;
        t_timer_beat got;
        if (!i_rst_n) begin
            timer_clear();
            beats_due.delete();
        end else begin
            if (i_cfg_we) apply_reg(i_cfg_idx, i_cfg_data);
            if (i_item.valid && i_item.ready) begin
                timer_step(t_kind'(i_item.kind), i_item.value, want);
                beats_due.push_back(want);
                o_items++;
                if (want.ev != EV_NONE) o_events++;
            end
            if (i_result.valid && i_result.ready) begin
                got.ev  = i_result.event_res;
                got.ts  = i_result.timestamp_us;
                got.ofs = i_result.frequency_offset;
                got.act = i_result.active;
                if (beats_due.size() == 0) begin
                    $display("%0t: beat with no item pending, expected none, actual ev %0d ts %0d",
                             $time, got.ev, got.ts);
                    o_fail_count++;
                end else begin
                    want = beats_due.pop_front();
                    if (got.ev != want.ev)
                        field_mismatch("event", want.ev, got.ev);
                    if (got.ts != want.ts)
                        field_mismatch("timestamp", want.ts, got.ts);
                    if (got.ofs != want.ofs)
                        field_mismatch("frequency offset", longint'($signed(want.ofs)),
                                       longint'($signed(got.ofs)));
                    if (got.act != want.act)
                        field_mismatch("active", want.act, got.act);
                end
            end
        end
        o_pending = beats_due.size();
    end

endmodule

>>> sim/tb_tick_tock_interval_timer_top.sv
`timescale 1ns / 1ps
module tb_tick_tock_interval_timer_top;
    import tti_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam logic signed [VAL_W-1:0] VAL_TOP    = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_BOTTOM = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_ONES   = '1;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int END_WAIT     = 20000;
    localparam int EVENT_GOAL   = 24;
    localparam int EXTRA_CAP    = 260;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int cycles;
    int cfg_writes;
    int check_fails;
    int pending;
    int items_seen;
    int events_seen;
    bit hold_req;

    tti_in_if  item_ch ();
    tti_out_if result_ch ();

    tick_tock_interval_timer_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    tti_timer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (check_fails),
        .o_pending    (pending),
        .o_items      (items_seen),
        .o_events     (events_seen)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("run stopped at cycle limit %0d", CYCLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off on request
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = $urandom_range(300, 500);
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] near_value(input int lo, input int hi);
        return VAL_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // one beat in: optional gap, then hold until taken; returns on a falling edge
    task automatic offer_item(input t_kind k, input logic signed [VAL_W-1:0] v);
        int gap;
        gap = 0;
        if (send_idle_pct > 0 && $urandom_range(99) < 3) begin
            gap = $urandom_range(20, 120);
        end else begin
            while ($urandom_range(99) < send_idle_pct) gap++;
        end
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind  <= k;
        item_ch.value <= v;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
    endtask

    // block idle: every beat back, then the processing latency
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // mostly counter clocks; offsets and phase shifts lean negative to keep periods short
    task automatic random_item();
        int                      r;
        t_kind                   k;
        logic signed [VAL_W-1:0] v;
        r = $urandom_range(999);
        v = VAL_W'($urandom);
        if (r < 860) begin
            k = K_CLOCK;
        end else if (r < 900) begin
            k = K_PHASE;
            if ($urandom_range(9) != 0) v = near_value(-2000, 500);
        end else if (r < 930) begin
            k = K_OFS_ADD;
            if ($urandom_range(9) != 0) v = near_value(-300, 150);
        end else if (r < 945) begin
            k = K_OFS_CLR;
        end else if (r < 970) begin
            k = K_START;
        end else if (r < 975) begin
            k = K_STOP;
        end else if (r < 985) begin
            k = K_PAUSE;
        end else begin
            k = K_RESUME;
        end
        offer_item(k, v);
    endtask

    task automatic run_phase(input int full, input int tks, input int n_items,
                             input int s_pct, input int r_pct, input bit squeeze,
                             input bit chase);
        int n;
        settle();
        cfg_write(CFG_FULL, CFG_DATA_W'(full));
        cfg_write(CFG_TICKS, CFG_DATA_W'(tks));
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        n = 0;
        while (n < n_items || (chase && events_seen < EVENT_GOAL && n < EXTRA_CAP)) begin
            if (squeeze && n == n_items / 2) hold_req = 1'b1;
            random_item();
            n++;
        end
    endtask

    initial begin : stimulus
        int waited;
        int total_fails;
        item_ch.valid  = 1'b0;
        item_ch.kind   = K_CLOCK;
        item_ch.value  = '0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_FULL;
        cfg_data       = '0;
        i_rst_n        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored commands, saturation, stop while paused
        offer_item(K_CLOCK, '0);
        offer_item(K_PAUSE, '0);
        offer_item(K_RESUME, '0);
        offer_item(K_START, '0);
        offer_item(K_CLOCK, VAL_ONES);
        offer_item(K_START, VAL_ONES);
        offer_item(K_PAUSE, '0);
        offer_item(K_PAUSE, '0);
        offer_item(K_CLOCK, '0);
        offer_item(K_RESUME, '0);
        offer_item(K_RESUME, '0);
        offer_item(K_PHASE, VAL_TOP);
        offer_item(K_PHASE, VAL_BOTTOM);
        offer_item(K_OFS_ADD, VAL_TOP);
        offer_item(K_OFS_ADD, VAL_BOTTOM);
        offer_item(K_OFS_CLR, VAL_ONES);
        offer_item(K_PAUSE, '0);
        offer_item(K_STOP, '0);
        offer_item(K_RESUME, '0);
        offer_item(K_START, '0);
        offer_item(K_CLOCK, '0);

        // writes to an unused index must change nothing
        settle();
        cfg_write(CFG_SPARE, '1);
        offer_item(K_CLOCK, '0);

        // random phases over register settings and idling modes
        run_phase(0, 0, 200, 0, 0, 1'b0, 1'b0);
        run_phase(2097151, 127, 30, 70, 0, 1'b0, 1'b0);
        run_phase(250, 1, 200, 0, 70, 1'b1, 1'b0);
        run_phase(2000000, 90, 30, 6, 6, 1'b0, 1'b0);
        run_phase(300, 1, 200, 6, 6, 1'b0, 1'b0);
        run_phase(200, 1, 220, 0, 0, 1'b0, 1'b1);

        // drain
        item_ch.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < END_WAIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        total_fails = check_fails;
        if (pending != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, pending);
            total_fails++;
        end

        $display("covered %0d items and %0d tick/tock events over %0d register writes",
                 items_seen, events_seen, cfg_writes);
        $display("idle modes: none, sender 70%%, receiver 70%% with a long hold-off, both 6%%");
        if (total_fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
